>>> rtl/qeo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeo_pkg
// Shared constants and types for the four-channel encoder odometer.
// ----------------------------------------------------------------------------
package qeo_pkg;

   localparam int PIN_BITS    = 4;
   localparam int MPC_BITS    = 24;
   localparam int INV_BITS    = 4;
   localparam int REPLY_BITS  = 64;
   localparam int REPLY_BYTES = 8;
   localparam int CNT_BITS    = 3;
   localparam int LOAD_BITS   = 56;
   localparam int TREE_LEAVES = 8;
   localparam int TREE_GROW   = 3;

   localparam logic OP_PIN  = 1'b0;
   localparam logic OP_BYTE = 1'b1;

   localparam logic [7:0] CMD_CH_FIRST = 8'd1;
   localparam logic [7:0] CMD_CH_LAST  = 8'd4;
   localparam logic [7:0] CMD_AVG      = 8'd5;
   localparam logic [7:0] CMD_CLEAR    = 8'h52;
   localparam logic [7:0] CMD_SET      = 8'h53;

   localparam logic REG_COUNT_STEP = 1'b0;
   localparam logic REG_DIR_INVERT = 1'b1;

   localparam logic [MPC_BITS-1:0] MPC_RESET = 24'd20011;
   localparam logic [INV_BITS-1:0] INV_RESET = 4'd10;

   typedef struct packed {
      logic sample;
      logic clear;
      logic load;
   } lane_ctrl_type;

   typedef struct packed {
      logic                  load;
      logic [REPLY_BITS-1:0] value;
   } reply_load_type;

endpackage

>>> rtl/qeo_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeo_lane
// One encoder channel: falling-edge detect on A and a wrapping distance
// accumulator that moves by the count step in the direction given by B and invert.
// ----------------------------------------------------------------------------
module qeo_lane #(
   parameter int DIST_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qeo_pkg::lane_ctrl_type        ctrl,
   input  logic                          pin_a,
   input  logic                          pin_b,
   input  logic                          invert,
   input  logic [qeo_pkg::MPC_BITS-1:0]  count_step,
   input  logic [DIST_BITS-1:0]          load_value,
   output logic [DIST_BITS-1:0]          distance
);

   logic                 prev_a_ff;
   logic [DIST_BITS-1:0] distance_ff;
   logic [DIST_BITS-1:0] step;
   logic                 fell;
   logic                 back;

   assign step     = DIST_BITS'(count_step);
   assign fell     = prev_a_ff & ~pin_a;
   assign back     = pin_b ^ invert;
   assign distance = distance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff   <= 1'b1;
         distance_ff <= '0;
      end else begin
         if (ctrl.sample) begin
            prev_a_ff <= pin_a;
            if (fell) begin
               distance_ff <= back ? (distance_ff - step) : (distance_ff + step);
            end
         end
         if (ctrl.clear) begin
            distance_ff <= '0;
         end
         if (ctrl.load) begin
            distance_ff <= load_value;
         end
      end
   end

endmodule

>>> rtl/qeo_avg_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeo_avg_tree
// Registered adder tree over the lane distances; start runs through p1_ff and
// p2_ff to load the floor of the sum over four, sign-extended to reply width.
// ----------------------------------------------------------------------------
module qeo_avg_tree #(
   parameter int NUM_CHANNELS = 4,
   parameter int DIST_BITS    = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIST_BITS-1:0]  lane_dist [NUM_CHANNELS],
   output qeo_pkg::reply_load_type result,
   output logic                  busy
);

   localparam int SUM_W = DIST_BITS + qeo_pkg::TREE_GROW;

   logic signed [SUM_W-1:0]     leaf  [qeo_pkg::TREE_LEAVES];
   logic signed [SUM_W-1:0]     s1_ff [qeo_pkg::TREE_LEAVES/2];
   logic signed [SUM_W-1:0]     s2_ff [qeo_pkg::TREE_LEAVES/4];
   logic signed [SUM_W-1:0]     total;
   logic signed [SUM_W-1:0]     quarter;
   logic signed [DIST_BITS-1:0] avg;
   logic                        p1_ff;
   logic                        p2_ff;

   for (genvar g = 0; g < qeo_pkg::TREE_LEAVES; g++) begin : g_leaf
      if (g < NUM_CHANNELS) begin : g_used
         assign leaf[g] = SUM_W'($signed(lane_dist[g]));
      end else begin : g_pad
         assign leaf[g] = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < qeo_pkg::TREE_LEAVES/2; k++) begin
         s1_ff[k] <= leaf[2*k] + leaf[2*k+1];
      end
      for (int k = 0; k < qeo_pkg::TREE_LEAVES/4; k++) begin
         s2_ff[k] <= s1_ff[2*k] + s1_ff[2*k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
      end else begin
         p1_ff <= start;
         p2_ff <= p1_ff;
      end
   end

   assign total        = s2_ff[0] + s2_ff[1];
   assign quarter      = total >>> 2;
   assign avg          = quarter[DIST_BITS-1:0];
   assign result.load  = p2_ff;
   assign result.value = qeo_pkg::REPLY_BITS'(avg);
   assign busy         = p1_ff | p2_ff;

endmodule

>>> rtl/qeo_tx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeo_tx
// Reply serializer: holds one 64-bit value and sends it as eight byte beats,
// least significant first, with last on the eighth.
// ----------------------------------------------------------------------------
module qeo_tx (
   input  logic                    clock,
   input  logic                    reset,
   input  qeo_pkg::reply_load_type load,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_tx_byte,
   output logic                    rsp_last,
   output logic                    busy
);

   localparam logic [qeo_pkg::CNT_BITS-1:0] LAST_BEAT =
      qeo_pkg::CNT_BITS'(qeo_pkg::REPLY_BYTES - 1);

   logic                            active_ff;
   logic [qeo_pkg::CNT_BITS-1:0]    count_ff;
   logic [qeo_pkg::REPLY_BITS-1:0]  shift_ff;
   logic                            beat;

   assign beat        = active_ff & rsp_ready;
   assign rsp_valid   = active_ff;
   assign rsp_tx_byte = shift_ff[7:0];
   assign rsp_last    = (count_ff == LAST_BEAT);
   assign busy        = active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else if (load.load) begin
         active_ff <= 1'b1;
         count_ff  <= '0;
      end else if (beat) begin
         count_ff <= count_ff + 1'b1;
         if (count_ff == LAST_BEAT) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         shift_ff <= load.value;
      end else if (beat) begin
         shift_ff <= shift_ff >> 8;
      end
   end

endmodule

>>> rtl/quad_encoder_odometer_cmd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_encoder_odometer_cmd_core
// Multi-channel wheel odometer with a byte command port.
//
// req_ beats carry either a pin sample (operation 0: A and B levels) or a
// received byte (operation 1). A falling edge of A moves that channel's
// distance by the count step. Bytes 1..4 reply with a channel distance, 5 with
// the average, 'R' clears, 'S' loads the next eight bytes into every channel.
// rsp_ beats carry replies: eight bytes, LSB first, last on the eighth.
// Pin samples are taken every cycle, also while a reply is being sent.
// A byte beat waits while a reply is queued or in flight: a channel reply
// starts in the cycle after its byte, an average reply after the two
// stages of the lane adder tree, and each reply then occupies rsp_ for eight
// beats at one per cycle when rsp_ready stays high. A stalled receiver holds
// the current byte and blocks further byte beats only.
// Reset clears all distances, sets the previous A levels to ones, ends any
// load in progress and restores the count step and direction_invert.
// csr_: APB-style, count step at 0x0, direction_invert at 0x4.
// ----------------------------------------------------------------------------
module quad_encoder_odometer_cmd_core #(
   parameter int NUM_CHANNELS = 4,
   parameter int DIST_BITS    = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [3:0]  req_enc_a,
   input  logic [3:0]  req_enc_b,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [qeo_pkg::CNT_BITS-1:0] LOAD_LAST =
      qeo_pkg::CNT_BITS'(qeo_pkg::REPLY_BYTES - 1);

   logic [qeo_pkg::MPC_BITS-1:0]  count_step_ff;
   logic [qeo_pkg::INV_BITS-1:0]  dir_invert_ff;
   logic                          loading_ff;
   logic [qeo_pkg::CNT_BITS-1:0]  load_count_ff;
   logic [qeo_pkg::LOAD_BITS-1:0] load_value_ff;

   logic                          csr_write;
   logic                          csr_index;
   logic                          pin_beat;
   logic                          byte_beat;
   logic                          cmd_beat;
   logic                          chan_cmd;
   logic                          avg_cmd;
   logic                          clear_cmd;
   logic                          set_cmd;
   logic                          load_done;
   logic                          tx_busy;
   logic                          avg_busy;
   logic [2:0]                    ch_sel;
   logic [qeo_pkg::REPLY_BITS-1:0] chan_value;
   logic [qeo_pkg::REPLY_BITS-1:0] load_full;
   logic [DIST_BITS-1:0]          lane_load;
   logic [DIST_BITS-1:0]          lane_dist [NUM_CHANNELS];
   qeo_pkg::lane_ctrl_type        lane_ctrl;
   qeo_pkg::reply_load_type       avg_result;
   qeo_pkg::reply_load_type       tx_load;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_step_ff <= qeo_pkg::MPC_RESET;
         dir_invert_ff <= qeo_pkg::INV_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            qeo_pkg::REG_COUNT_STEP: count_step_ff <= csr_pwdata[qeo_pkg::MPC_BITS-1:0];
            qeo_pkg::REG_DIR_INVERT: dir_invert_ff <= csr_pwdata[qeo_pkg::INV_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         qeo_pkg::REG_COUNT_STEP: csr_prdata = 32'(count_step_ff);
         qeo_pkg::REG_DIR_INVERT: csr_prdata = 32'(dir_invert_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // Input decode
   assign req_ready = (req_operation == qeo_pkg::OP_PIN) | ~(tx_busy | avg_busy);
   assign pin_beat  = req_valid & req_ready & (req_operation == qeo_pkg::OP_PIN);
   assign byte_beat = req_valid & req_ready & (req_operation == qeo_pkg::OP_BYTE);
   assign cmd_beat  = byte_beat & ~loading_ff;
   assign load_done = byte_beat & loading_ff & (load_count_ff == LOAD_LAST);

   assign chan_cmd  = cmd_beat & (req_rx_byte >= qeo_pkg::CMD_CH_FIRST)
                    & (req_rx_byte <= qeo_pkg::CMD_CH_LAST)
                    & (req_rx_byte <= 8'(NUM_CHANNELS));
   assign avg_cmd   = cmd_beat & (req_rx_byte == qeo_pkg::CMD_AVG);
   assign clear_cmd = cmd_beat & (req_rx_byte == qeo_pkg::CMD_CLEAR);
   assign set_cmd   = cmd_beat & (req_rx_byte == qeo_pkg::CMD_SET);

   assign lane_ctrl.sample = pin_beat;
   assign lane_ctrl.clear  = clear_cmd;
   assign lane_ctrl.load   = load_done;

   assign load_full = {req_rx_byte, load_value_ff};
   assign lane_load = load_full[DIST_BITS-1:0];

   // Load payload collection
   always_ff @(posedge clock) begin
      if (reset) begin
         loading_ff    <= 1'b0;
         load_count_ff <= '0;
      end else if (set_cmd) begin
         loading_ff    <= 1'b1;
         load_count_ff <= '0;
      end else if (byte_beat & loading_ff) begin
         load_count_ff <= load_count_ff + 1'b1;
         if (load_count_ff == LOAD_LAST) begin
            loading_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (byte_beat & loading_ff) begin
         for (int k = 0; k < qeo_pkg::REPLY_BYTES - 1; k++) begin
            if (load_count_ff == qeo_pkg::CNT_BITS'(k)) begin
               load_value_ff[8*k +: 8] <= req_rx_byte;
            end
         end
      end
   end

   // Lanes
   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
      logic pin_a;
      logic pin_b;
      logic invert;
      if (g < qeo_pkg::PIN_BITS) begin : g_pins
         assign pin_a  = req_enc_a[g];
         assign pin_b  = req_enc_b[g];
         assign invert = dir_invert_ff[g];
      end else begin : g_nopins
         assign pin_a  = 1'b1;
         assign pin_b  = 1'b0;
         assign invert = 1'b0;
      end
      qeo_lane #(
         .DIST_BITS (DIST_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .pin_a      (pin_a),
         .pin_b      (pin_b),
         .invert     (invert),
         .count_step (count_step_ff),
         .load_value (lane_load),
         .distance   (lane_dist[g])
      );
   end

   // Merge: channel select and average
   assign ch_sel = req_rx_byte[2:0] - 3'd1;

   always_comb begin
      chan_value = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (ch_sel == 3'(i)) begin
            chan_value = qeo_pkg::REPLY_BITS'($signed(lane_dist[i]));
         end
      end
   end

   qeo_avg_tree #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .DIST_BITS    (DIST_BITS)
   ) u_avg_tree (
      .clock     (clock),
      .reset     (reset),
      .start     (avg_cmd),
      .lane_dist (lane_dist),
      .result    (avg_result),
      .busy      (avg_busy)
   );

   assign tx_load.load  = chan_cmd | avg_result.load;
   assign tx_load.value = chan_cmd ? chan_value : avg_result.value;

   qeo_tx u_tx (
      .clock       (clock),
      .reset       (reset),
      .load        (tx_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last),
      .busy        (tx_busy)
   );

endmodule

>>> dv/quad_encoder_odometer_cmd_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_encoder_odometer_cmd_core_tb
// Self-checking bench for the four-channel encoder odometer.
//
// Drives pin samples and command bytes on req_ and tracks the distances,
// load state and registers in a local odometer model. Every byte leaving
// rsp_ is compared with the next reply byte the model has queued. Directed
// cases cover counting in both directions, loads carrying command codes,
// clears and unknown bytes. A long receiver hold-off fills the block.
// Random phases then run at several register settings, the extremes among
// them, with a stalling receiver and bursty requests in all but one phase.
// ----------------------------------------------------------------------------
module quad_encoder_odometer_cmd_core_tb;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 5;
   localparam int NUM_CHANNELS   = 4;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 42;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } tx_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_operation;
   logic [3:0]  req_enc_a;
   logic [3:0]  req_enc_b;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // odometer model state
   logic [63:0]                  wheel_dist [NUM_CHANNELS];
   logic [3:0]                   prev_pin_a;
   logic                         load_active;
   logic [2:0]                   load_idx;
   logic [55:0]                  load_word;
   logic [qeo_pkg::MPC_BITS-1:0] cfg_count_step;
   logic [qeo_pkg::INV_BITS-1:0] cfg_dir_invert;

   tx_beat_type pending_tx [$];

   int  fail_count;
   int  stuck_cycles;
   int  hold_request;
   int  hold_left;
   int  burst_left;
   bit  steady_sender;
   logic [3:0] last_sent_a;

   quad_encoder_odometer_cmd_core #(
      .NUM_CHANNELS(NUM_CHANNELS),
      .DIST_BITS   (64)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_enc_a    (req_enc_a),
      .req_enc_b    (req_enc_b),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_last     (rsp_last),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("ERROR %0t: %s", $time, msg);
   endtask

   task automatic queue_distance_reply(input logic [63:0] value);
      tx_beat_type beat;
      for (int k = 0; k < qeo_pkg::REPLY_BYTES; k++) begin
         beat.tx_byte = value[8*k +: 8];
         beat.last    = (k == qeo_pkg::REPLY_BYTES - 1);
         pending_tx.push_back(beat);
      end
   endtask

   task automatic step_odometer(input logic op, input logic [3:0] a, input logic [3:0] b,
                                input logic [7:0] rxb);
      logic signed [65:0] sum;
      logic [63:0]        value;
      if (op == qeo_pkg::OP_PIN) begin
         for (int i = 0; i < qeo_pkg::PIN_BITS; i++) begin
            if (prev_pin_a[i] && !a[i]) begin
               if (b[i] ^ cfg_dir_invert[i])
                  wheel_dist[i] = wheel_dist[i] - {40'd0, cfg_count_step};
               else
                  wheel_dist[i] = wheel_dist[i] + {40'd0, cfg_count_step};
            end
         end
         prev_pin_a = a;
      end else if (load_active) begin
         if (load_idx == 3'd7) begin
            value = {rxb, load_word};
            for (int i = 0; i < NUM_CHANNELS; i++) wheel_dist[i] = value;
            load_active = 1'b0;
            load_idx    = 3'd0;
         end else begin
            load_word[8*load_idx +: 8] = rxb;
            load_idx = load_idx + 3'd1;
         end
      end else if (rxb >= qeo_pkg::CMD_CH_FIRST && rxb <= qeo_pkg::CMD_CH_LAST) begin
         queue_distance_reply(wheel_dist[rxb - qeo_pkg::CMD_CH_FIRST]);
      end else if (rxb == qeo_pkg::CMD_AVG) begin
         sum = '0;
         for (int i = 0; i < NUM_CHANNELS; i++)
            sum = sum + $signed({{2{wheel_dist[i][63]}}, wheel_dist[i]});
         sum   = sum >>> 2;
         value = sum[63:0];
         queue_distance_reply(value);
      end else if (rxb == qeo_pkg::CMD_CLEAR) begin
         for (int i = 0; i < NUM_CHANNELS; i++) wheel_dist[i] = '0;
      end else if (rxb == qeo_pkg::CMD_SET) begin
         load_active = 1'b1;
         load_idx    = 3'd0;
         load_word   = '0;
      end
   endtask

   task automatic compare_tx_beat();
      tx_beat_type want;
      if (pending_tx.size() == 0) begin
         log_failure($sformatf("unexpected reply beat tx_byte=%02h last=%0b",
                               rsp_tx_byte, rsp_last));
      end else begin
         want = pending_tx.pop_front();
         if (rsp_tx_byte !== want.tx_byte)
            log_failure($sformatf("tx_byte expected %02h actual %02h",
                                  want.tx_byte, rsp_tx_byte));
         if (rsp_last !== want.last)
            log_failure($sformatf("last expected %0b actual %0b", want.last, rsp_last));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            step_odometer(req_operation, req_enc_a, req_enc_b, req_rx_byte);
         if (rsp_valid && rsp_ready) compare_tx_beat();
      end
   end

   // receiver: ready runs and stall runs, with an on-demand hold-off
   initial begin
      int  run_left;
      bit  run_ready;
      run_left  = 0;
      run_ready = 1'b0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            if (run_left == 0) begin
               run_ready = !run_ready;
               if (run_ready)
                  run_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 14);
               else
                  run_left = $urandom_range(1, 5);
            end
            run_left--;
            rsp_ready <= run_ready;
         end
      end
   end

   initial begin
      stuck_cycles = 0;
      while (stuck_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_beat(input logic op, input logic [3:0] a, input logic [3:0] b,
                            input logic [7:0] rxb);
      int gap;
      if (!steady_sender) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_enc_a     <= a;
      req_enc_b     <= b;
      req_rx_byte   <= rxb;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_pins(input logic [3:0] a, input logic [3:0] b);
      last_sent_a = a;
      send_beat(qeo_pkg::OP_PIN, a, b, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_pins();
      logic [3:0] a;
      if ($urandom_range(0, 1)) a = last_sent_a ^ 4'($urandom_range(1, 15));
      else a = 4'($urandom_range(0, 15));
      send_pins(a, 4'($urandom_range(0, 15)));
   endtask

   task automatic send_byte(input logic [7:0] rxb);
      send_beat(qeo_pkg::OP_BYTE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                rxb);
   endtask

   task automatic wait_replies_done();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_tx.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == qeo_pkg::REG_COUNT_STEP) cfg_count_step = data[qeo_pkg::MPC_BITS-1:0];
      else cfg_dir_invert = data[qeo_pkg::INV_BITS-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic test_reset_readout();
      send_byte(qeo_pkg::CMD_CH_FIRST);
      send_byte(qeo_pkg::CMD_AVG);
      wait_replies_done();
   endtask

   task automatic test_count_edges();
      send_pins(4'hF, 4'h0);
      send_pins(4'h0, 4'h0);
      send_pins(4'hF, 4'h0);
      send_pins(4'h0, 4'h0);
      send_pins(4'hF, 4'hF);
      send_pins(4'h0, 4'h6);
      for (logic [7:0] c = qeo_pkg::CMD_CH_FIRST; c <= qeo_pkg::CMD_CH_LAST; c++)
         send_byte(c);
      wait_replies_done();
   endtask

   task automatic test_load_and_clear();
      // command codes inside the payload are data
      send_byte(qeo_pkg::CMD_SET);
      send_byte(qeo_pkg::CMD_CH_FIRST);
      send_byte(qeo_pkg::CMD_AVG);
      send_pins(4'h9, 4'h0);
      send_byte(qeo_pkg::CMD_CLEAR);
      send_byte(qeo_pkg::CMD_SET);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_byte(8'h80);
      send_pins(4'h0, 4'h0);
      send_byte(qeo_pkg::CMD_AVG);
      send_byte(8'hFF);
      send_byte(qeo_pkg::CMD_CLEAR);
      send_byte(qeo_pkg::CMD_CH_LAST);
      wait_replies_done();
   endtask

   task automatic test_backpressure();
      hold_request  = HOLD_CYCLES;
      steady_sender = 1'b1;
      send_byte(qeo_pkg::CMD_CH_FIRST);
      send_random_pins();
      send_random_pins();
      send_byte(qeo_pkg::CMD_AVG);
      send_random_pins();
      send_byte(qeo_pkg::CMD_CH_LAST);
      send_byte(qeo_pkg::CMD_CH_FIRST + 8'd1);
      send_random_pins();
      steady_sender = 1'b0;
      wait_replies_done();
   endtask

   task automatic run_random_phase(input int n_items);
      int         done;
      int         pick;
      int         extra;
      logic [7:0] top;
      done = 0;
      while (done < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_random_pins();
            done++;
         end else if (pick < 75) begin
            send_byte(8'($urandom_range(qeo_pkg::CMD_CH_FIRST, qeo_pkg::CMD_CH_LAST)));
            done++;
         end else if (pick < 82) begin
            send_byte(qeo_pkg::CMD_AVG);
            done++;
         end else if (pick < 85) begin
            send_byte(qeo_pkg::CMD_CLEAR);
            done++;
         end else if (pick < 93) begin
            case ($urandom_range(0, 4))
               0: top = 8'h7F;
               1: top = 8'h80;
               2: top = 8'hFF;
               3: top = 8'h00;
               default: top = 8'($urandom_range(0, 255));
            endcase
            send_byte(qeo_pkg::CMD_SET);
            for (int k = 0; k < qeo_pkg::REPLY_BYTES; k++) begin
               if ($urandom_range(0, 3) == 0) begin
                  send_random_pins();
                  done++;
               end
               send_byte((k == qeo_pkg::REPLY_BYTES - 1) ? top : 8'($urandom_range(0, 255)));
            end
            done += qeo_pkg::REPLY_BYTES + 1;
         end else if (pick < 96) begin
            // cut the payload short: following items finish the load
            send_byte(qeo_pkg::CMD_SET);
            extra = $urandom_range(1, 7);
            repeat (extra) send_byte(8'($urandom_range(0, 255)));
            done += extra + 1;
         end else begin
            send_byte(8'($urandom_range(0, 255)));
            done++;
         end
      end
   endtask

   task automatic test_random();
      logic [31:0] mpc_word;
      logic [31:0] inv_word;
      for (int ph = 0; ph < 4; ph++) begin
         mpc_word = $urandom;
         inv_word = $urandom;
         case (ph)
            0: begin
               mpc_word[qeo_pkg::MPC_BITS-1:0] =
                  qeo_pkg::MPC_BITS'($urandom_range(1, 24'hFFFFFF));
            end
            1: begin
               mpc_word[qeo_pkg::MPC_BITS-1:0] = 24'hFFFFFF;
               inv_word[qeo_pkg::INV_BITS-1:0] = 4'hF;
            end
            2: begin
               mpc_word[qeo_pkg::MPC_BITS-1:0] = 24'd1;
               inv_word[qeo_pkg::INV_BITS-1:0] = 4'h0;
            end
            default: begin
               mpc_word[qeo_pkg::MPC_BITS-1:0] =
                  qeo_pkg::MPC_BITS'($urandom_range(1, 200000));
            end
         endcase
         csr_write(qeo_pkg::REG_COUNT_STEP, mpc_word);
         csr_write(qeo_pkg::REG_DIR_INVERT, inv_word);
         steady_sender = (ph == 2);
         run_random_phase(PHASE_ITEMS);
         steady_sender = 1'b0;
         wait_replies_done();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = qeo_pkg::OP_PIN;
      req_enc_a     = 4'hF;
      req_enc_b     = 4'h0;
      req_rx_byte   = 8'h00;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      fail_count    = 0;
      hold_request  = 0;
      burst_left    = 0;
      steady_sender = 1'b0;
      last_sent_a   = 4'hF;
      for (int i = 0; i < NUM_CHANNELS; i++) wheel_dist[i] = '0;
      prev_pin_a     = 4'hF;
      load_active    = 1'b0;
      load_idx       = 3'd0;
      load_word      = '0;
      cfg_count_step = qeo_pkg::MPC_RESET;
      cfg_dir_invert = qeo_pkg::INV_RESET;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_reset_readout();
      test_count_edges();
      test_load_and_clear();
      test_backpressure();
      test_random();
      wait_replies_done();

      if (fail_count == 0 && pending_tx.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
